/* design/cle_pkg.sv */
// ----------------------------------------------------------------------------
// cle_pkg: shared types and constants of the canonical line editor
// Result kinds, internal result descriptors, character codes and defaults.
// ----------------------------------------------------------------------------
package cle_pkg;

    localparam int DEFAULT_BUFFER_DEPTH = 256;

    localparam logic       ECHO_ENABLE_RESET = 1'b1;
    localparam logic [8:0] LINE_LENGTH_RESET = 9'd64;

    // Register indexes on the configuration port
    localparam logic REG_ECHO_ENABLE = 1'b0;
    localparam logic REG_LINE_LENGTH = 1'b1;

    // Item commands
    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Character codes
    localparam logic [7:0] CHAR_EOT   = 8'h04;
    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;

    typedef enum logic [2:0] {
        KIND_ECHO      = 3'd0,
        KIND_DATA      = 3'd1,
        KIND_EOF       = 3'd2,
        KIND_NOT_READY = 3'd3,
        KIND_REFUSED   = 3'd4
    } kind_t;

    // What an accepted item turns into on the result side
    typedef enum logic [2:0] {
        OP_NONE,
        OP_ECHO,
        OP_BACKSPACE,
        OP_DATA,
        OP_EOF,
        OP_NOT_READY,
        OP_REFUSED
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
        logic       line_end;
    } desc_t;

    typedef struct packed {
        logic       echo_enable;
        logic [8:0] line_length;
    } cfg_t;

endpackage

/* design/cle_in_if.sv */
// ----------------------------------------------------------------------------
// cle_in_if: item channel of the line editor
// Valid/ready channel carrying a command and a received key byte.
// ----------------------------------------------------------------------------
interface cle_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] key_char;

    modport source (output valid, output cmd, output key_char, input ready);
    modport sink   (input valid, input cmd, input key_char, output ready);
endinterface

/* design/cle_out_if.sv */
// ----------------------------------------------------------------------------
// cle_out_if: result channel of the line editor
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface cle_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       line_end;
    logic       last;

    modport source (output valid, output kind, output data_byte, output line_end,
                    output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input line_end,
                    input last, output ready);
endinterface

/* design/cle_ram.sv */
// ----------------------------------------------------------------------------
// cle_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/cle_editor.sv */
// ----------------------------------------------------------------------------
// cle_editor: line state and line store access
// Updates positions per item, writes keys, reads line bytes, emits descriptors.
// ----------------------------------------------------------------------------
module cle_editor #(
    parameter int BUFFER_DEPTH = cle_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  cle_pkg::cfg_t  cfg,
    cle_in_if.sink         item,
    output logic           desc_valid,
    input  logic           desc_ready,
    output cle_pkg::desc_t desc
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int PW = $clog2(BUFFER_DEPTH + 1);
    localparam int LW = (PW > 9) ? PW : 9;

    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic          pending_reg, pending_next;
    logic          s1_valid_reg, s1_valid_next;
    cle_pkg::desc_t s1_desc_reg, desc_new;

    logic          accept;
    logic [LW-1:0] len_clip;
    logic [LW-1:0] cap_full;
    logic [PW-1:0] cap;
    logic [PW-1:0] rp_inc;
    logic [7:0]    c;
    logic          show;
    logic          wr_en;
    logic          rd_en;
    logic [7:0]    rd_data;

    // Capacity: min(line_length, depth) - 3, floored at zero
    always_comb
    begin
        len_clip = (LW'(cfg.line_length) > LW'(BUFFER_DEPTH))
                   ? LW'(BUFFER_DEPTH) : LW'(cfg.line_length);
        cap_full = (len_clip > LW'(3)) ? len_clip - LW'(3) : '0;
        cap      = cap_full[PW-1:0];
    end

    assign item.ready = !s1_valid_reg || desc_ready;
    assign accept     = item.valid && item.ready;
    assign rp_inc     = rp_reg + PW'(1);
    assign c          = (item.key_char == cle_pkg::CHAR_CR) ? cle_pkg::CHAR_LF
                                                            : item.key_char;

    always_comb
    begin
        wp_next           = wp_reg;
        rp_next           = rp_reg;
        pending_next      = pending_reg;
        wr_en             = 1'b0;
        rd_en             = 1'b0;
        show              = 1'b0;
        desc_new.op       = cle_pkg::OP_NONE;
        desc_new.ch       = c;
        desc_new.line_end = 1'b0;
        if (item.cmd == cle_pkg::CMD_READ)
        begin
            if (!pending_reg)
            begin
                desc_new.op = cle_pkg::OP_NOT_READY;
            end
            else if (rp_reg >= wp_reg)
            begin
                desc_new.op  = cle_pkg::OP_EOF;
                wp_next      = '0;
                rp_next      = '0;
                pending_next = 1'b0;
            end
            else
            begin
                desc_new.op = cle_pkg::OP_DATA;
                rd_en       = accept;
                rp_next     = rp_inc;
                if (rp_inc >= wp_reg)
                begin
                    desc_new.line_end = 1'b1;
                    wp_next           = '0;
                    rp_next           = '0;
                    pending_next      = 1'b0;
                end
            end
        end
        else if (pending_reg)
        begin
            desc_new.op = cle_pkg::OP_REFUSED;
        end
        else if (c == cle_pkg::CHAR_EOT)
        begin
            pending_next = 1'b1;
            rp_next      = '0;
        end
        else if (c == cle_pkg::CHAR_BS)
        begin
            if (wp_reg != '0)
            begin
                wp_next = wp_reg - PW'(1);
                if (cfg.echo_enable)
                begin
                    desc_new.op = cle_pkg::OP_BACKSPACE;
                end
            end
        end
        else
        begin
            show = (c == cle_pkg::CHAR_LF) ||
                   (cfg.echo_enable && c >= cle_pkg::CHAR_SPACE &&
                    c <= cle_pkg::CHAR_TILDE);
            if (wp_reg < cap)
            begin
                wr_en   = accept;
                wp_next = wp_reg + PW'(1);
            end
            else
            begin
                show = 1'b0;
            end
            if (show)
            begin
                desc_new.op = cle_pkg::OP_ECHO;
            end
            if (c == cle_pkg::CHAR_LF)
            begin
                pending_next = 1'b1;
                rp_next      = '0;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg && !desc_ready;
        if (accept)
        begin
            s1_valid_next = (desc_new.op != cle_pkg::OP_NONE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            rp_reg       <= '0;
            pending_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                wp_reg      <= wp_next;
                rp_reg      <= rp_next;
                pending_reg <= pending_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_desc_reg <= desc_new;
        end
    end

    cle_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg[AW-1:0]),
        .wr_data (c),
        .rd_en   (rd_en),
        .rd_addr (rp_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // Read data arrives with the descriptor; it holds while the stage stalls
    always_comb
    begin
        desc = s1_desc_reg;
        if (s1_desc_reg.op == cle_pkg::OP_DATA)
        begin
            desc.ch = rd_data;
        end
    end

    assign desc_valid = s1_valid_reg;

endmodule

/* design/cle_beat.sv */
// ----------------------------------------------------------------------------
// cle_beat: result beat sequencer
// Holds one descriptor and expands it into one or three result transfers.
// ----------------------------------------------------------------------------
module cle_beat (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           desc_valid,
    output logic           desc_ready,
    input  cle_pkg::desc_t desc,
    cle_out_if.source      result
);

    logic           busy_reg, busy_next;
    logic [1:0]     idx_reg, idx_next;
    cle_pkg::desc_t cur_reg;
    logic           is_last;
    logic           load;

    assign is_last    = (cur_reg.op != cle_pkg::OP_BACKSPACE) || (idx_reg == 2'd2);
    assign desc_ready = !busy_reg || (result.ready && is_last);
    assign load       = desc_ready && desc_valid;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (desc_ready)
        begin
            busy_next = desc_valid;
            idx_next  = '0;
        end
        else if (result.ready)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= desc;
        end
    end

    always_comb
    begin
        result.kind      = cle_pkg::KIND_ECHO;
        result.data_byte = '0;
        case (cur_reg.op)
            cle_pkg::OP_ECHO:
            begin
                result.data_byte = cur_reg.ch;
            end
            cle_pkg::OP_BACKSPACE:
            begin
                result.data_byte = (idx_reg == 2'd1) ? cle_pkg::CHAR_SPACE
                                                     : cle_pkg::CHAR_BS;
            end
            cle_pkg::OP_DATA:
            begin
                result.kind      = cle_pkg::KIND_DATA;
                result.data_byte = cur_reg.ch;
            end
            cle_pkg::OP_EOF:       result.kind = cle_pkg::KIND_EOF;
            cle_pkg::OP_NOT_READY: result.kind = cle_pkg::KIND_NOT_READY;
            cle_pkg::OP_REFUSED:   result.kind = cle_pkg::KIND_REFUSED;
            default:               result.kind = cle_pkg::KIND_ECHO;
        endcase
    end

    assign result.valid    = busy_reg;
    assign result.line_end = (cur_reg.op == cle_pkg::OP_DATA) && cur_reg.line_end;
    assign result.last     = is_last;

endmodule

/* design/canonical_line_editor.sv */
// ----------------------------------------------------------------------------
// canonical_line_editor: canonical terminal line editor
// Edits one line from keystrokes with echo, then hands it out byte by byte.
// ----------------------------------------------------------------------------
// The item transfer loads its descriptor and line store read into the editor
// stage register; the beat sequencer then loads both into its result register,
// from which the first result is offered. Throughput: one item per cycle
// while each item yields at most one result and results are taken as offered;
// a backspace echo holds the single result register for three transfers.
// Reset: line empty, no line pending, pipeline empty, echo on, length 64. The
// line store is not cleared; no entry is read before it was written.
// ----------------------------------------------------------------------------
module canonical_line_editor #(
    parameter int BUFFER_DEPTH = cle_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    cle_in_if.sink      item,
    cle_out_if.source   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic           echo_enable_reg;
    logic [8:0]     line_length_reg;
    logic           cfg_write;
    logic           reg_index;
    cle_pkg::cfg_t  cfg;
    logic           desc_valid;
    logic           desc_ready;
    cle_pkg::desc_t desc;

    // ------------------------------------------------------------------
    // Configuration port: zero wait states; register index is the word
    // address, the byte offset bits are ignored.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_enable_reg <= cle_pkg::ECHO_ENABLE_RESET;
            line_length_reg <= cle_pkg::LINE_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            if (reg_index == cle_pkg::REG_ECHO_ENABLE)
            begin
                echo_enable_reg <= pwdata[0];
            end
            else
            begin
                line_length_reg <= pwdata[8:0];
            end
        end
    end

    // Read back: return the addressed register, zero extended
    always_comb
    begin
        case (reg_index)
            cle_pkg::REG_ECHO_ENABLE: prdata = {31'b0, echo_enable_reg};
            cle_pkg::REG_LINE_LENGTH: prdata = {23'b0, line_length_reg};
            default:                  prdata = '0;
        endcase
    end

    assign cfg.echo_enable = echo_enable_reg;
    assign cfg.line_length = line_length_reg;

    // ------------------------------------------------------------------
    // Editor: line positions and pending flag live here; the line store is
    // written on keystrokes and read on line reads. Writes happen only while
    // no line is pending and data reads only while one is, so a store entry
    // is never read in the same cycle it is written.
    // ------------------------------------------------------------------
    cle_editor #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_editor (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item       (item),
        .desc_valid (desc_valid),
        .desc_ready (desc_ready),
        .desc       (desc)
    );

    // ------------------------------------------------------------------
    // Result side: hold one descriptor and advance through its beats; the
    // next descriptor loads in the same cycle the last beat transfers.
    // ------------------------------------------------------------------
    cle_beat u_beat (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (desc_valid),
        .desc_ready (desc_ready),
        .desc       (desc),
        .result     (result)
    );

endmodule
